FILE: rtl/safety_interlock_state_machine_defines.svh
// Assertion macros for the safety interlock state machine
`ifndef SAFETY_INTERLOCK_STATE_MACHINE_DEFINES_SVH
`define SAFETY_INTERLOCK_STATE_MACHINE_DEFINES_SVH

// check on every clock edge outside reset
`define SISM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check on every clock edge, reset included
`define SISM_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: rtl/sism_pkg.sv
// Types, codes and inhibit masks shared by the safety interlock state machine
package sism_pkg;

   localparam int INHIBIT_WIDTH = 14;

   typedef enum logic [2:0] {
      ST_BOOTING  = 3'd0,
      ST_DISARMED = 3'd1,
      ST_ARMED    = 3'd2,
      ST_FAULTED  = 3'd3,
      ST_MAINT    = 3'd4,
      ST_OTA      = 3'd5
   } op_state_type;

   typedef enum logic [3:0] {
      CMD_BOOT_DONE   = 4'd0,
      CMD_SET_INHIBIT = 4'd1,
      CMD_FAULT       = 4'd2,
      CMD_ARM         = 4'd3,
      CMD_DISARM      = 4'd4,
      CMD_MAINT       = 4'd5,
      CMD_CLOSE_MAINT = 4'd6,
      CMD_OTA         = 4'd7,
      CMD_ACK         = 4'd8,
      CMD_AUTH_MOTION = 4'd9,
      CMD_AUTH_CFG    = 4'd10,
      CMD_AUTH_OTA    = 4'd11
   } command_type;

   typedef enum logic [2:0] {
      OC_APPLIED       = 3'd0,
      OC_NO_CHANGE     = 3'd1,
      OC_REJ_STATE     = 3'd2,
      OC_REJ_INHIBITED = 3'd3,
      OC_REJ_LATCHED   = 3'd4,
      OC_INVALID       = 3'd5
   } outcome_type;

   typedef logic [INHIBIT_WIDTH-1:0] inhibit_type;

   localparam logic [2:0] ACT_NONE    = 3'b000;
   localparam logic [2:0] ACT_ESTOP   = 3'b001;
   localparam logic [2:0] ACT_REVOKE  = 3'b010;
   localparam logic [2:0] ACT_REQSTOP = 3'b100;

   localparam inhibit_type INH_NONE             = 14'h0000;
   localparam inhibit_type INH_SELF_TEST_FAILED = 14'h2000;

   localparam inhibit_type ARM_BLOCKERS         = 14'h3FFF;
   localparam inhibit_type MAINT_ENTRY_BLOCKERS = 14'h3E30;
   localparam inhibit_type MAINT_WRITE_BLOCKERS = 14'h3E3C;
   localparam inhibit_type MAINT_TRIP_INHIBITS  = 14'h1C30;
   localparam inhibit_type OTA_ENTRY_BLOCKERS   = 14'h3E3C;
   localparam inhibit_type OTA_TRIP_INHIBITS    = 14'h0430;
   localparam inhibit_type FAULT_ACK_BLOCKERS   = 14'h3E7C;

   typedef struct packed {
      op_state_type op_state;
      inhibit_type  active;
      inhibit_type  latched;
   } ctrl_state_type;

   typedef struct packed {
      outcome_type  outcome;
      op_state_type prev_state;
      op_state_type cur_state;
      inhibit_type  blocker;
      logic [2:0]   action;
      logic         bump;
      logic         invalid;
   } step_result_type;

   function automatic inhibit_type trip_mask(input op_state_type s);
      inhibit_type r;
      case (s)
         ST_ARMED: r = ARM_BLOCKERS;
         ST_MAINT: r = MAINT_TRIP_INHIBITS;
         ST_OTA:   r = OTA_TRIP_INHIBITS;
         default:  r = INH_NONE;
      endcase
      return r;
   endfunction

endpackage

FILE: rtl/sism_step.sv
// Decision logic for one command: next control state and result fields
module sism_step (
   input  logic [3:0]               cmd_raw,
   input  logic [15:0]              mask,
   input  sism_pkg::ctrl_state_type cur,
   output sism_pkg::ctrl_state_type nxt,
   output sism_pkg::step_result_type res
);
   import sism_pkg::*;

   command_type  cmd;
   logic         bad;
   inhibit_type  m;
   inhibit_type  trip;
   inhibit_type  causes;
   logic         bump;

   op_state_type g_from;
   op_state_type g_to;
   inhibit_type  g_block;
   logic         g_chk;
   logic         g_clear;
   logic         g_ok;
   logic         g_lat;
   inhibit_type  g_blk;
   logic         g_pass;

   op_state_type q_need;
   inhibit_type  q_block;
   inhibit_type  q_blk;

   assign cmd    = command_type'(cmd_raw);
   assign bad    = |mask[15:INHIBIT_WIDTH];
   assign m      = mask[INHIBIT_WIDTH-1:0];
   assign trip   = m & trip_mask(cur.op_state);
   assign causes = m | (cur.active & INH_SELF_TEST_FAILED);

   // decode guarded moves and authorization queries
   always_comb begin
      g_from  = ST_DISARMED;
      g_to    = ST_DISARMED;
      g_block = INH_NONE;
      g_chk   = 1'b0;
      g_clear = 1'b0;
      q_need  = ST_ARMED;
      q_block = ARM_BLOCKERS;
      unique case (cmd)
         CMD_ARM: begin
            g_to    = ST_ARMED;
            g_block = ARM_BLOCKERS;
            g_chk   = 1'b1;
         end
         CMD_MAINT: begin
            g_to    = ST_MAINT;
            g_block = MAINT_ENTRY_BLOCKERS;
            g_chk   = 1'b1;
         end
         CMD_CLOSE_MAINT: begin
            g_from  = ST_MAINT;
         end
         CMD_OTA: begin
            g_to    = ST_OTA;
            g_block = OTA_ENTRY_BLOCKERS;
            g_chk   = 1'b1;
         end
         CMD_ACK: begin
            g_from  = ST_FAULTED;
            g_block = FAULT_ACK_BLOCKERS;
            g_clear = 1'b1;
         end
         CMD_AUTH_CFG: begin
            q_need  = ST_MAINT;
            q_block = MAINT_WRITE_BLOCKERS;
         end
         CMD_AUTH_OTA: begin
            q_need  = ST_OTA;
            q_block = OTA_ENTRY_BLOCKERS;
         end
         default: begin
            g_from  = ST_DISARMED;
         end
      endcase
   end

   assign g_ok   = cur.op_state == g_from;
   assign g_lat  = g_chk && (cur.latched != INH_NONE);
   assign g_blk  = cur.active & g_block;
   assign g_pass = g_ok && !g_lat && (g_blk == INH_NONE);
   assign q_blk  = cur.active & q_block;

   // next control state
   always_comb begin
      nxt  = cur;
      bump = 1'b0;
      unique case (cmd)
         CMD_BOOT_DONE: begin
            if (!bad && cur.op_state == ST_BOOTING) begin
               bump = 1'b1;
               if (causes == INH_NONE) begin
                  nxt.op_state = ST_DISARMED;
               end else begin
                  nxt.op_state = ST_FAULTED;
                  nxt.active   = cur.active | causes;
                  nxt.latched  = cur.latched | causes;
               end
            end
         end
         CMD_SET_INHIBIT: begin
            if (!bad) begin
               nxt.active = m;
               bump = cur.active != m;
               if (trip != INH_NONE) begin
                  nxt.op_state = ST_FAULTED;
                  nxt.latched  = cur.latched | trip;
                  bump = bump || (cur.op_state != ST_FAULTED) ||
                         ((cur.latched | trip) != cur.latched);
               end
            end
         end
         CMD_FAULT: begin
            if (!bad && m != INH_NONE) begin
               nxt.op_state = ST_FAULTED;
               nxt.active   = cur.active | m;
               nxt.latched  = cur.latched | m;
               bump = (cur.op_state != ST_FAULTED) ||
                      ((cur.active | m) != cur.active) ||
                      ((cur.latched | m) != cur.latched);
            end
         end
         CMD_DISARM: begin
            if (cur.op_state == ST_ARMED) begin
               nxt.op_state = ST_DISARMED;
               bump = 1'b1;
            end
         end
         CMD_ARM, CMD_MAINT, CMD_CLOSE_MAINT, CMD_OTA, CMD_ACK: begin
            if (g_pass) begin
               nxt.op_state = g_to;
               bump = 1'b1;
               if (g_clear) begin
                  nxt.latched = INH_NONE;
               end
            end
         end
         default: begin
            bump = 1'b0;
         end
      endcase
   end

   // result fields
   always_comb begin
      res.outcome    = OC_APPLIED;
      res.prev_state = cur.op_state;
      res.cur_state  = nxt.op_state;
      res.blocker    = INH_NONE;
      res.action     = ACT_NONE;
      res.bump       = bump;
      res.invalid    = 1'b0;
      unique case (cmd)
         CMD_BOOT_DONE: begin
            if (bad) begin
               res.invalid = 1'b1;
            end else if (cur.op_state != ST_BOOTING) begin
               res.outcome = OC_REJ_STATE;
            end else begin
               res.blocker = causes;
               if (causes != INH_NONE) begin
                  res.action = ACT_ESTOP | ACT_REVOKE;
               end
            end
         end
         CMD_SET_INHIBIT: begin
            if (bad) begin
               res.invalid = 1'b1;
            end else begin
               res.outcome = bump ? OC_APPLIED : OC_NO_CHANGE;
               res.blocker = trip;
               if (trip != INH_NONE) begin
                  res.action = ACT_ESTOP | ACT_REVOKE;
               end
            end
         end
         CMD_FAULT: begin
            if (bad || m == INH_NONE) begin
               res.invalid = 1'b1;
            end else begin
               res.outcome = bump ? OC_APPLIED : OC_NO_CHANGE;
               res.blocker = m;
               res.action  = ACT_ESTOP | ACT_REVOKE;
            end
         end
         CMD_DISARM: begin
            if (cur.op_state == ST_DISARMED) begin
               res.outcome = OC_NO_CHANGE;
            end else if (cur.op_state == ST_ARMED) begin
               res.action = ACT_REQSTOP | ACT_REVOKE;
            end else begin
               res.outcome = OC_REJ_STATE;
            end
         end
         CMD_ARM, CMD_MAINT, CMD_CLOSE_MAINT, CMD_OTA, CMD_ACK: begin
            if (!g_ok) begin
               res.outcome = OC_REJ_STATE;
            end else if (g_lat) begin
               res.outcome = OC_REJ_LATCHED;
               res.blocker = cur.latched;
            end else if (g_blk != INH_NONE) begin
               res.outcome = OC_REJ_INHIBITED;
               res.blocker = g_blk;
            end else if (g_to != ST_ARMED) begin
               res.action = ACT_REQSTOP | ACT_REVOKE;
            end
         end
         CMD_AUTH_MOTION, CMD_AUTH_CFG, CMD_AUTH_OTA: begin
            if (cur.op_state != q_need) begin
               res.outcome = OC_REJ_STATE;
            end else if (cur.latched != INH_NONE) begin
               res.outcome = OC_REJ_LATCHED;
               res.blocker = cur.latched;
            end else begin
               res.blocker = q_blk;
               res.outcome = (q_blk != INH_NONE) ? OC_REJ_INHIBITED : OC_APPLIED;
            end
         end
         default: begin
            res.invalid = 1'b1;
         end
      endcase
      if (res.invalid) begin
         res.outcome    = OC_INVALID;
         res.prev_state = ST_BOOTING;
         res.cur_state  = ST_BOOTING;
         res.blocker    = INH_NONE;
         res.action     = ACT_NONE;
      end
   end

endmodule

FILE: rtl/safety_interlock_state_machine.sv
// Safety interlock state machine top level: item register, decision logic, result register
//
// Takes one command item per clock cycle, back to back. An item accepted at one edge is
// registered in the item register, decided there by the command decode and mask logic, and its
// result is loaded into the result register and offered on rsp_valid when the item advances.
// Throughput is one item per cycle as long as rsp_stall stays low; while a result waits, the
// registered item holds and req_stall rises. The control state (operational state,
// active and latched inhibit masks, REVISION_WIDTH-bit revision counter) updates at the same
// edge that loads the result register, so each item sees the state left by the one before.
// rsp_revision_count carries the low 32 bits of the revision, zero extended when the counter
// is narrower. Reset puts the block in booting with all masks and the revision cleared.
module safety_interlock_state_machine #(
   parameter int REVISION_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_command,
   input  logic [15:0] req_inhibit_mask,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_outcome,
   output logic [2:0]  rsp_state_before,
   output logic [2:0]  rsp_state_after,
   output logic [13:0] rsp_blocker_mask,
   output logic [2:0]  rsp_action_bits,
   output logic [31:0] rsp_revision_count
);
   import sism_pkg::*;

   logic                      item_valid_ff;
   logic [3:0]                item_command_ff;
   logic [15:0]               item_mask_ff;

   ctrl_state_type            ctrl_ff;
   ctrl_state_type            ctrl_in;
   logic [REVISION_WIDTH-1:0] revision_ff;
   logic [REVISION_WIDTH-1:0] revision_in;

   step_result_type           res;

   logic                      rsp_valid_ff;
   logic [2:0]                rsp_outcome_ff;
   logic [2:0]                rsp_prev_ff;
   logic [2:0]                rsp_cur_ff;
   logic [13:0]               rsp_blocker_ff;
   logic [2:0]                rsp_action_ff;
   logic [31:0]               rsp_revision_ff;

   logic                      advance;
   logic                      accept;

   logic [$bits(ctrl_state_type)+REVISION_WIDTH-1:0] held_state;
   logic                      state_faulted;
   logic                      fault_latched;
   logic                      item_rejected;
   logic                      rsp_invalid;
   logic                      rsp_cleared;

   assign advance   = item_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = item_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   sism_step u_step (
      .cmd_raw (item_command_ff),
      .mask    (item_mask_ff),
      .cur     (ctrl_ff),
      .nxt     (ctrl_in),
      .res     (res)
   );

   assign revision_in = res.bump ? REVISION_WIDTH'(revision_ff + 1'b1) : revision_ff;

   // hold the item register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (accept) begin
         item_valid_ff <= 1'b1;
      end else if (advance) begin
         item_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_command_ff <= req_command;
         item_mask_ff    <= req_inhibit_mask;
      end
   end

   // advance control state
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.op_state <= ST_BOOTING;
         ctrl_ff.active   <= INH_NONE;
         ctrl_ff.latched  <= INH_NONE;
         revision_ff      <= '0;
      end else if (advance) begin
         ctrl_ff     <= ctrl_in;
         revision_ff <= revision_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_outcome_ff  <= res.outcome;
         rsp_prev_ff     <= res.prev_state;
         rsp_cur_ff      <= res.cur_state;
         rsp_blocker_ff  <= res.blocker;
         rsp_action_ff   <= res.action;
         rsp_revision_ff <= res.invalid ? 32'd0 : 32'(revision_in);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_outcome        = rsp_outcome_ff;
   assign rsp_state_before   = rsp_prev_ff;
   assign rsp_state_after    = rsp_cur_ff;
   assign rsp_blocker_mask   = rsp_blocker_ff;
   assign rsp_action_bits    = rsp_action_ff;
   assign rsp_revision_count = rsp_revision_ff;

   assign held_state    = {ctrl_ff, revision_ff};
   assign state_faulted = ctrl_ff.op_state == ST_FAULTED;
   assign fault_latched = ctrl_ff.latched != INH_NONE;
   assign item_rejected = advance &&
                          (res.outcome inside {OC_REJ_STATE, OC_REJ_LATCHED,
                                               OC_REJ_INHIBITED, OC_INVALID});
   assign rsp_invalid   = rsp_valid_ff && rsp_outcome_ff == OC_INVALID;
   assign rsp_cleared   = rsp_revision_ff == 32'd0 && rsp_cur_ff == ST_BOOTING &&
                          rsp_prev_ff == ST_BOOTING;

`include "safety_interlock_state_machine_defines.svh"

   `SISM_ASSERT(a_hold_state, !advance |=> $stable(held_state), "state moved while idle")
   `SISM_ASSERT(a_faulted_latched, state_faulted |-> fault_latched, "faulted with no latched fault")
   `SISM_ASSERT(a_reject_keeps_rev, item_rejected |=> $stable(held_state), "rejection changed state")
   `SISM_ASSERT(a_invalid_zero, rsp_invalid |-> rsp_cleared, "invalid result not cleared")

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the safety interlock state machine with an interlock scoreboard
module testbench;
   import sism_pkg::*;

   typedef struct {
      outcome_type  outcome;
      op_state_type prev_state;
      op_state_type cur_state;
      inhibit_type  blocker;
      logic [2:0]   action;
      logic [31:0]  revision;
   } interlock_response_type;

   class interlock_scoreboard_type;
      op_state_type           op_state;
      inhibit_type            active;
      inhibit_type            latched;
      logic [31:0]            revision;
      interlock_response_type responses[$];
      int                     errors;

      function new();
         op_state = ST_BOOTING;
         active   = INH_NONE;
         latched  = INH_NONE;
         revision = '0;
         errors   = 0;
      endfunction

      function int pending();
         return responses.size();
      endfunction

      function inhibit_type trip_inhibits(op_state_type s);
         if (s == ST_ARMED) return ARM_BLOCKERS;
         if (s == ST_MAINT) return MAINT_TRIP_INHIBITS;
         if (s == ST_OTA) return OTA_TRIP_INHIBITS;
         return INH_NONE;
      endfunction

      function interlock_response_type invalid_result();
         interlock_response_type r;
         r.outcome    = OC_INVALID;
         r.prev_state = ST_BOOTING;
         r.cur_state  = ST_BOOTING;
         r.blocker    = INH_NONE;
         r.action     = ACT_NONE;
         r.revision   = '0;
         return r;
      endfunction

      function interlock_response_type rejection(outcome_type oc, inhibit_type blk);
         interlock_response_type r;
         r.outcome    = oc;
         r.prev_state = op_state;
         r.cur_state  = op_state;
         r.blocker    = blk;
         r.action     = ACT_NONE;
         r.revision   = revision;
         return r;
      endfunction

      function interlock_response_type settle(op_state_type prev, logic changed,
                                              inhibit_type blk, logic [2:0] act);
         interlock_response_type r;
         if (changed) revision = revision + 32'd1;
         r.outcome    = changed ? OC_APPLIED : OC_NO_CHANGE;
         r.prev_state = prev;
         r.cur_state  = op_state;
         r.blocker    = blk;
         r.action     = act;
         r.revision   = revision;
         return r;
      endfunction

      function interlock_response_type guarded_move(op_state_type from, inhibit_type blockers,
                                                    logic check_latched, logic clear_latched,
                                                    op_state_type to);
         op_state_type prev;
         if (op_state != from) return rejection(OC_REJ_STATE, INH_NONE);
         if (check_latched && latched != INH_NONE) return rejection(OC_REJ_LATCHED, latched);
         if ((active & blockers) != INH_NONE)
            return rejection(OC_REJ_INHIBITED, active & blockers);
         if (clear_latched) latched = INH_NONE;
         prev     = op_state;
         op_state = to;
         return settle(prev, 1'b1, INH_NONE,
                       (to == ST_ARMED) ? ACT_NONE : (ACT_REQSTOP | ACT_REVOKE));
      endfunction

      function interlock_response_type authorize(op_state_type need, inhibit_type blockers);
         inhibit_type blk;
         if (op_state != need) return rejection(OC_REJ_STATE, INH_NONE);
         if (latched != INH_NONE) return rejection(OC_REJ_LATCHED, latched);
         blk = active & blockers;
         return rejection((blk != INH_NONE) ? OC_REJ_INHIBITED : OC_APPLIED, blk);
      endfunction

      function void note_command(logic [3:0] cmd, logic [15:0] raw);
         interlock_response_type r;
         logic                   bad;
         logic                   changed;
         logic [2:0]             act;
         inhibit_type            m;
         inhibit_type            trip;
         inhibit_type            causes;
         inhibit_type            old_active;
         inhibit_type            old_latched;
         op_state_type           prev;
         bad         = |raw[15:14];
         m           = raw[13:0];
         prev        = op_state;
         old_active  = active;
         old_latched = latched;
         case (cmd)
            CMD_BOOT_DONE: begin
               if (bad) begin
                  r = invalid_result();
               end else if (op_state != ST_BOOTING) begin
                  r = rejection(OC_REJ_STATE, INH_NONE);
               end else begin
                  causes = m | (active & INH_SELF_TEST_FAILED);
                  if (causes == INH_NONE) begin
                     op_state = ST_DISARMED;
                     r = settle(prev, 1'b1, INH_NONE, ACT_NONE);
                  end else begin
                     active   = active | causes;
                     latched  = latched | causes;
                     op_state = ST_FAULTED;
                     r = settle(prev, 1'b1, causes, ACT_ESTOP | ACT_REVOKE);
                  end
               end
            end
            CMD_SET_INHIBIT: begin
               if (bad) begin
                  r = invalid_result();
               end else begin
                  changed = (active != m);
                  active  = m;
                  trip    = m & trip_inhibits(op_state);
                  act     = ACT_NONE;
                  if (trip != INH_NONE) begin
                     latched  = latched | trip;
                     op_state = ST_FAULTED;
                     changed  = changed || (prev != op_state) || (old_latched != latched);
                     act      = ACT_ESTOP | ACT_REVOKE;
                  end
                  r = settle(prev, changed, trip, act);
               end
            end
            CMD_FAULT: begin
               if (bad || m == INH_NONE) begin
                  r = invalid_result();
               end else begin
                  active   = active | m;
                  latched  = latched | m;
                  op_state = ST_FAULTED;
                  changed  = (prev != op_state) || (old_active != active) ||
                             (old_latched != latched);
                  r = settle(prev, changed, m, ACT_ESTOP | ACT_REVOKE);
               end
            end
            CMD_ARM: r = guarded_move(ST_DISARMED, ARM_BLOCKERS, 1'b1, 1'b0, ST_ARMED);
            CMD_DISARM: begin
               if (op_state == ST_DISARMED) begin
                  r = settle(prev, 1'b0, INH_NONE, ACT_NONE);
               end else if (op_state != ST_ARMED) begin
                  r = rejection(OC_REJ_STATE, INH_NONE);
               end else begin
                  op_state = ST_DISARMED;
                  r = settle(prev, 1'b1, INH_NONE, ACT_REQSTOP | ACT_REVOKE);
               end
            end
            CMD_MAINT: r = guarded_move(ST_DISARMED, MAINT_ENTRY_BLOCKERS, 1'b1, 1'b0, ST_MAINT);
            CMD_CLOSE_MAINT: r = guarded_move(ST_MAINT, INH_NONE, 1'b0, 1'b0, ST_DISARMED);
            CMD_OTA: r = guarded_move(ST_DISARMED, OTA_ENTRY_BLOCKERS, 1'b1, 1'b0, ST_OTA);
            CMD_ACK: r = guarded_move(ST_FAULTED, FAULT_ACK_BLOCKERS, 1'b0, 1'b1, ST_DISARMED);
            CMD_AUTH_MOTION: r = authorize(ST_ARMED, ARM_BLOCKERS);
            CMD_AUTH_CFG: r = authorize(ST_MAINT, MAINT_WRITE_BLOCKERS);
            CMD_AUTH_OTA: r = authorize(ST_OTA, OTA_ENTRY_BLOCKERS);
            default: r = invalid_result();
         endcase
         responses.push_back(r);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_response(logic [2:0] outcome, logic [2:0] prev_s, logic [2:0] cur_s,
                                   logic [13:0] blk, logic [2:0] act, logic [31:0] rev);
         interlock_response_type e;
         if (responses.size() == 0) begin
            $display("%0t: unexpected response, outcome 0x%0h revision 0x%0h",
                     $time, outcome, rev);
            errors++;
            return;
         end
         e = responses.pop_front();
         compare_field("outcome", e.outcome, outcome);
         compare_field("state_before", e.prev_state, prev_s);
         compare_field("state_after", e.cur_state, cur_s);
         compare_field("blocker_mask", e.blocker, blk);
         compare_field("action_bits", e.action, act);
         compare_field("revision_count", e.revision, rev);
      endfunction
   endclass

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 700;
   localparam logic [3:0] CMD_UNUSED_LOW  = 4'd12;
   localparam logic [3:0] CMD_UNUSED_HIGH = 4'd15;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [3:0]  req_command;
   logic [15:0] req_inhibit_mask;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_outcome;
   logic [2:0]  rsp_state_before;
   logic [2:0]  rsp_state_after;
   logic [13:0] rsp_blocker_mask;
   logic [2:0]  rsp_action_bits;
   logic [31:0] rsp_revision_count;

   interlock_scoreboard_type board;
   int                       items_sent;
   int                       burst_left;
   int                       cycles;
   int                       stall_mode;
   int                       stall_left;

   safety_interlock_state_machine u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_inhibit_mask   (req_inhibit_mask),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_outcome        (rsp_outcome),
      .rsp_state_before   (rsp_state_before),
      .rsp_state_after    (rsp_state_after),
      .rsp_blocker_mask   (rsp_blocker_mask),
      .rsp_action_bits    (rsp_action_bits),
      .rsp_revision_count (rsp_revision_count)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("** safety_interlock_state_machine: FAILED **");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(3);
         stall_left <= $urandom_range(120, 10);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(3) == 0);
         2: rsp_stall <= ($urandom_range(3) != 0);
         default: rsp_stall <= stall_left[2];
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_response(rsp_outcome, rsp_state_before, rsp_state_after,
                              rsp_blocker_mask, rsp_action_bits, rsp_revision_count);
   end

   function automatic logic [15:0] pick_mask();
      case ($urandom_range(9))
         0, 1, 2, 3: return 16'h0000;
         4, 5, 6: return 16'h0001 << $urandom_range(13);
         7: return 16'($urandom_range(16'h3FFF));
         default: return 16'($urandom_range(16'hFFFF));
      endcase
   endfunction

   task automatic send_item(input logic [3:0] cmd, input logic [15:0] mask);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(8, 1)) @(posedge clock);
         burst_left = $urandom_range(40, 1);
      end
      burst_left--;
      req_valid        <= 1'b1;
      req_command      <= cmd;
      req_inhibit_mask <= mask;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_command(cmd, mask);
      items_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   task automatic return_to_disarmed();
      while (board.op_state != ST_DISARMED) begin
         case (board.op_state)
            ST_FAULTED: begin
               send_item(CMD_SET_INHIBIT, 16'h0000);
               send_item(CMD_ACK, 16'h0000);
            end
            ST_ARMED: send_item(CMD_DISARM, pick_mask());
            ST_MAINT: send_item(CMD_CLOSE_MAINT, pick_mask());
            ST_OTA: send_item(CMD_FAULT, 16'h0001 << $urandom_range(13));
            default: send_item(CMD_BOOT_DONE, 16'h0000);
         endcase
      end
   endtask

   task automatic run_scenario();
      int n;
      case ($urandom_range(9))
         0, 1: begin
            return_to_disarmed();
            if ($urandom_range(1)) send_item(CMD_SET_INHIBIT, pick_mask());
            send_item(CMD_ARM, pick_mask());
            send_item(CMD_AUTH_MOTION, pick_mask());
            if ($urandom_range(1)) send_item(CMD_SET_INHIBIT, pick_mask());
            send_item(CMD_AUTH_MOTION, pick_mask());
            send_item(CMD_DISARM, pick_mask());
         end
         2: begin
            return_to_disarmed();
            send_item(CMD_SET_INHIBIT, pick_mask());
            send_item(CMD_MAINT, pick_mask());
            send_item(CMD_AUTH_CFG, pick_mask());
            send_item(CMD_SET_INHIBIT, pick_mask());
            send_item(CMD_AUTH_CFG, pick_mask());
            send_item(CMD_CLOSE_MAINT, pick_mask());
         end
         3: begin
            return_to_disarmed();
            send_item(CMD_SET_INHIBIT, pick_mask());
            send_item(CMD_OTA, pick_mask());
            send_item(CMD_AUTH_OTA, pick_mask());
            send_item(CMD_SET_INHIBIT, pick_mask());
            send_item(CMD_AUTH_OTA, pick_mask());
         end
         4: begin
            send_item(CMD_FAULT, pick_mask());
            send_item(CMD_ACK, pick_mask());
            send_item(CMD_SET_INHIBIT, 16'h0000);
            send_item(CMD_ACK, pick_mask());
         end
         5, 6: begin
            n = $urandom_range(8, 3);
            repeat (n) send_item(4'($urandom_range(15)), 16'($urandom_range(16'hFFFF)));
         end
         default: begin
            n = $urandom_range(6, 3);
            repeat (n) send_item(4'($urandom_range(CMD_AUTH_OTA)), pick_mask());
         end
      endcase
   endtask

   initial begin
      board            = new();
      clock            = 1'b0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_command      = CMD_BOOT_DONE;
      req_inhibit_mask = 16'h0000;
      rsp_stall        = 1'b0;
      items_sent       = 0;
      burst_left       = 0;
      cycles           = 0;
      stall_mode       = 0;
      stall_left       = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(CMD_UNUSED_LOW, 16'h0000);
      send_item(CMD_UNUSED_HIGH, 16'hFFFF);
      send_item(CMD_BOOT_DONE, 16'hC000);
      send_item(CMD_FAULT, 16'h0000);
      send_item(CMD_SET_INHIBIT, 16'h8000);
      send_item(CMD_ARM, 16'h0000);
      send_item(CMD_DISARM, 16'h0000);
      send_item(CMD_AUTH_MOTION, 16'h0000);
      send_item(CMD_AUTH_CFG, 16'h0000);
      send_item(CMD_AUTH_OTA, 16'h0000);
      send_item(CMD_SET_INHIBIT, {2'b00, INH_SELF_TEST_FAILED});
      send_item(CMD_SET_INHIBIT, {2'b00, INH_SELF_TEST_FAILED});
      send_item(CMD_BOOT_DONE, 16'h0000);
      send_item(CMD_ACK, 16'h0000);
      send_item(CMD_SET_INHIBIT, 16'h0000);
      send_item(CMD_ACK, 16'h0000);
      send_item(CMD_BOOT_DONE, 16'h3FFF);
      send_item(CMD_DISARM, 16'h0000);
      send_item(CMD_ARM, 16'h0000);
      send_item(CMD_AUTH_MOTION, 16'h0000);
      send_item(CMD_SET_INHIBIT, 16'h3FFF);
      send_item(CMD_FAULT, 16'h3FFF);
      send_item(CMD_SET_INHIBIT, 16'h0000);
      send_item(CMD_ACK, 16'h0000);
      send_item(CMD_MAINT, 16'h0000);
      send_item(CMD_AUTH_CFG, 16'h0000);
      send_item(CMD_CLOSE_MAINT, 16'h0000);
      send_item(CMD_OTA, 16'h0000);
      send_item(CMD_SET_INHIBIT, 16'h0010);
      drain();

      items_sent = 0;
      while (items_sent < RANDOM_ITEMS / 2) run_scenario();
      drain();
      while (items_sent < RANDOM_ITEMS) run_scenario();

      drain();
      repeat (8) @(posedge clock);
      if (board.errors == 0) begin
         $display("** safety_interlock_state_machine: PASSED **");
      end else begin
         $display("** safety_interlock_state_machine: FAILED **");
      end
      $finish;
   end
endmodule
